@@ rtl/core/crc8_resync_packet_framer_core_defines.svh @@
// Assertion macros for the CRC-8 packet framer checker.
// No dependencies; included by the checker file only.
`ifndef CRC8_RESYNC_PACKET_FRAMER_CORE_DEFINES_SVH
`define CRC8_RESYNC_PACKET_FRAMER_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CRC8RPF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer check failed: same-cycle implication");

// next-cycle implication, disabled while in reset
`define CRC8RPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer check failed: next-cycle implication");

`endif

@@ rtl/core/crc8rpf_pkg.sv @@
// Shared types, constants and the CRC-8/Maxim byte step for the framer.
// No dependencies.
`default_nettype none

package crc8rpf_pkg;

    localparam int unsigned WIN_LEN = 9;
    localparam int unsigned HELD_W  = $clog2(WIN_LEN + 1);

    localparam logic [7:0] CRC_POLY = 8'h8C;
    localparam logic [7:0] CRC_INIT = 8'h00;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_ID_LOWEST  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_ID_HIGHEST = CFG_INDEX_W'(1);

    localparam logic [7:0] ID_LOWEST_RESET  = 8'd1;
    localparam logic [7:0] ID_HIGHEST_RESET = 8'd4;

    // one link of the cell chain: a window byte and the CRC of it and all newer bytes
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] crc;
    } link_t;

    typedef struct packed {
        logic [7:0]  device_id;
        logic [7:0]  op_mode;
        logic [15:0] torque_cur;
        logic [15:0] speed_value;
        logic [15:0] position_value;
        logic [7:0]  fault_code;
    } result_t;

    // reflected CRC-8, one byte absorbed
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/crc8rpf_cell.sv @@
// One cell of the window chain: holds a byte and its running CRC.
// Depends on crc8rpf_pkg.
`default_nettype none

module crc8rpf_cell (
    input  wire logic               clk,
    input  wire logic               shift,
    input  wire logic [7:0]         rx_byte,
    input  wire crc8rpf_pkg::link_t link_in,
    output crc8rpf_pkg::link_t      link_out
);

    crc8rpf_pkg::link_t link_reg;
    crc8rpf_pkg::link_t link_next;

    // take the newer neighbour's byte and fold the arriving byte into its CRC
    always_comb
    begin
        link_next = link_reg;
        if (shift)
        begin
            link_next.data = link_in.data;
            link_next.crc  = crc8rpf_pkg::crc8_step(link_in.crc, rx_byte);
        end
    end

    always_ff @(posedge clk)
    begin
        link_reg <= link_next;
    end

    assign link_out = link_reg;

endmodule

`default_nettype wire

@@ rtl/core/crc8rpf_result_reg.sv @@
// Output register for decoded packets, with valid/ready towards the sink.
// Depends on crc8rpf_pkg.
`default_nettype none

module crc8rpf_result_reg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire crc8rpf_pkg::result_t result_in,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic                      can_take,
    output crc8rpf_pkg::result_t      result_out
);

    logic                 valid_reg;
    logic                 valid_next;
    crc8rpf_pkg::result_t data_reg;
    crc8rpf_pkg::result_t data_next;

    // free when empty or when the waiting beat leaves this cycle
    assign can_take = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (can_take)
        begin
            valid_next = load;
            if (load)
            begin
                data_next = result_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid  = valid_reg;
    assign result_out = data_reg;

endmodule

`default_nettype wire

@@ rtl/core/crc8_resync_packet_framer_core.sv @@
// Fixed-length packet framer: takes one received byte per beat and delivers one decoded
// result per 10-byte packet whose first byte is an ID within [id_lowest, id_highest] and
// whose tenth byte is the CRC-8/Maxim (poly 0x8C reflected, init 0) of the first nine.
// Throughput is one byte per clock: a chain of nine cells holds the window, each cell
// keeping the CRC of its byte and every newer one, so the full-window CRC is always
// ready in the oldest cell and each cell folds in a single byte per beat. A result is
// registered and appears the cycle after the beat carrying the check byte; rx ready
// drops only while a result is waiting and the sink is stalling. After a match the
// window restarts empty and nine more bytes are needed before the next check. No
// clearing pass is needed after reset. Registers: index 0 id_lowest, index 1
// id_highest; other indexes are ignored. Depends on crc8rpf_pkg, crc8rpf_cell,
// crc8rpf_result_reg.
`default_nettype none

module crc8_resync_packet_framer_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [7:0]                          rx_byte,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [7:0]                               device_id,
    output logic [7:0]                               op_mode,
    output logic signed [15:0]                       torque_cur,
    output logic signed [15:0]                       speed_value,
    output logic [15:0]                              position_value,
    output logic [7:0]                               fault_code,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [crc8rpf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                          cfg_data
);

    localparam int unsigned WL = crc8rpf_pkg::WIN_LEN;
    localparam int unsigned HW = crc8rpf_pkg::HELD_W;

    logic [7:0]    id_lowest_reg;
    logic [7:0]    id_lowest_next;
    logic [7:0]    id_highest_reg;
    logic [7:0]    id_highest_next;
    logic [HW-1:0] held_count_reg;
    logic [HW-1:0] held_count_next;

    crc8rpf_pkg::link_t   chain [WL];
    crc8rpf_pkg::result_t result_d;
    crc8rpf_pkg::result_t result_q;

    logic in_accept;
    logic full;
    logic id_ok;
    logic match;
    logic can_take;

    assign cfg_ready = 1'b1;
    assign in_ready  = can_take;
    assign in_accept = in_valid && in_ready;

    // ---- window chain, index 0 is the oldest byte ----
    for (genvar j = 0; j < WL; j++)
    begin : g_cell
        crc8rpf_pkg::link_t link_in;
        if (j == WL - 1)
        begin : g_head
            assign link_in = '{data: rx_byte, crc: crc8rpf_pkg::CRC_INIT};
        end
        else
        begin : g_body
            assign link_in = chain[j+1];
        end

        crc8rpf_cell u_cell (
            .clk      (clk),
            .shift    (in_accept),
            .rx_byte  (rx_byte),
            .link_in  (link_in),
            .link_out (chain[j])
        );
    end

    // ---- match decision ----
    assign full  = (held_count_reg == HW'(WL));
    assign id_ok = (chain[0].data >= id_lowest_reg) && (chain[0].data <= id_highest_reg);
    assign match = full && id_ok && (chain[0].crc == rx_byte);

    always_comb
    begin
        held_count_next = held_count_reg;
        if (in_accept)
        begin
            if (match)
            begin
                held_count_next = '0;
            end
            else if (!full)
            begin
                held_count_next = held_count_reg + HW'(1);
            end
        end
    end

    // ---- configuration ----
    always_comb
    begin
        id_lowest_next  = id_lowest_reg;
        id_highest_next = id_highest_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                crc8rpf_pkg::CFG_ID_LOWEST:  id_lowest_next  = cfg_data;
                crc8rpf_pkg::CFG_ID_HIGHEST: id_highest_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_lowest_reg  <= crc8rpf_pkg::ID_LOWEST_RESET;
            id_highest_reg <= crc8rpf_pkg::ID_HIGHEST_RESET;
            held_count_reg <= '0;
        end
        else
        begin
            id_lowest_reg  <= id_lowest_next;
            id_highest_reg <= id_highest_next;
            held_count_reg <= held_count_next;
        end
    end

    // ---- result unpacking and output register ----
    always_comb
    begin
        result_d.device_id      = chain[0].data;
        result_d.op_mode        = chain[1].data;
        result_d.torque_cur     = {chain[2].data, chain[3].data};
        result_d.speed_value    = {chain[4].data, chain[5].data};
        result_d.position_value = {chain[6].data, chain[7].data};
        result_d.fault_code     = chain[8].data;
    end

    crc8rpf_result_reg u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_accept && match),
        .result_in  (result_d),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .can_take   (can_take),
        .result_out (result_q)
    );

    assign device_id      = result_q.device_id;
    assign op_mode        = result_q.op_mode;
    assign torque_cur     = $signed(result_q.torque_cur);
    assign speed_value    = $signed(result_q.speed_value);
    assign position_value = result_q.position_value;
    assign fault_code     = result_q.fault_code;

endmodule

`default_nettype wire

@@ rtl/core/crc8rpf_checker.sv @@
// Port-level checks for the framer, bound to the top level.
// Depends on the assertion macro header.
`default_nettype none

`include "crc8_resync_packet_framer_core_defines.svh"

module crc8rpf_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [7:0]         device_id,
    input wire logic [7:0]         op_mode,
    input wire logic signed [15:0] torque_cur,
    input wire logic signed [15:0] speed_value,
    input wire logic [15:0]        position_value,
    input wire logic [7:0]         fault_code
);

    logic        out_stall;
    logic [71:0] payload;

    assign out_stall = out_valid && !out_ready;
    assign payload   = {device_id, op_mode, torque_cur, speed_value,
                        position_value, fault_code};

    // a stalled result beat stays put
    `CRC8RPF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid)
    `CRC8RPF_ASSERT_NEXT(a_out_stable, clk, rst_n, out_stall, $stable(payload))

    // rx side is only held off by a waiting, stalled result
    `CRC8RPF_ASSERT_IMPLY(a_ready_skid, clk, rst_n, !in_ready, out_stall)

    // a new result beat only follows an accepted rx beat
    `CRC8RPF_ASSERT_IMPLY(a_out_cause, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready))

endmodule

bind crc8_resync_packet_framer_core crc8rpf_checker u_checker (.*);

`default_nettype wire
